### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define TMC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tmc_pkg.sv
// types, constants and helper functions of the time window median clamp block
package tmc_pkg;

   localparam int Depth    = 32;
   localparam int SlotW    = $clog2(Depth);
   localparam int CntW     = $clog2(Depth + 1);
   localparam int SumW     = CntW + 1;
   localparam int DataW    = 32;
   localparam int CountW   = 6;
   localparam int LimitW   = 31;
   localparam int CsrIdxW  = 1;

   localparam logic [DataW-1:0]  WindowReset = 32'd1000000;
   localparam logic [LimitW-1:0] LimitReset  = 31'h7fff_ffff;

   typedef logic [SlotW-1:0] slot_type;
   typedef logic [CntW-1:0]  cnt_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_WINDOW_TICKS = 1'b0,
      CSR_CLAMP_LIMIT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        [DataW-1:0] stamp;
      logic signed [DataW-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0]  filtered_value;
      logic        [CountW-1:0] window_count;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic cmp;
   } rank_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_EV_RD,
      ST_EV_CHK,
      ST_C_RD,
      ST_C_LD,
      ST_COUNT,
      ST_EVAL,
      ST_MEDIAN,
      ST_DONE
   } state_type;

   // ring index of base + off, with base below Depth and off at most Depth
   function automatic slot_type slot_add(slot_type base, cnt_type off);
      logic [SumW-1:0] sum;
      sum = SumW'(base) + SumW'(off);
      if (sum >= SumW'(Depth)) begin
         sum = sum - SumW'(Depth);
      end
      return sum[SlotW-1:0];
   endfunction

   // symmetric clamp of a 33 bit signed value
   function automatic logic signed [DataW-1:0] clamp_val(logic signed [DataW:0] v,
                                                          logic [LimitW-1:0] lim);
      logic signed [DataW:0] pos;
      logic signed [DataW:0] neg;
      logic signed [DataW:0] r;
      pos = $signed({2'b00, lim});
      neg = -pos;
      if (v > pos) begin
         r = pos;
      end else if (v < neg) begin
         r = neg;
      end else begin
         r = v;
      end
      return r[DataW-1:0];
   endfunction

endpackage

### rtl/time_window_median_clamp_top.sv
// time window median clamp: sequencer, ring memories and rank counter
// the first item after reset is only clamped; each later item is written to the ring, then
// expired entries are evicted from the oldest, then candidates are ranked one at a time by the
// single compare walking the value ram until both middle values are found
// one item at a time: req_ready is low from accept until the result is in the output register
// reset (synchronous, active high) empties the ring and restores register defaults
`include "assert_macros.svh"

module time_window_median_clamp_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tmc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tmc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  tmc_pkg::csr_index_type              csr_index,
   input  logic [tmc_pkg::DataW-1:0]           csr_wdata
);
   import tmc_pkg::*;

   state_type               state_ff, state_in;
   logic                    started_ff, started_in;
   cnt_type                 held_ff, held_in;
   slot_type                oldest_ff, oldest_in;
   logic [DataW-1:0]        window_ff, window_in;
   logic [LimitW-1:0]       limit_ff, limit_in;
   logic [DataW-1:0]        t_ff, t_in;
   logic signed [DataW-1:0] v_ff, v_in;
   cnt_type                 ci_ff, ci_in;
   cnt_type                 ja_ff, ja_in;
   logic                    pend_ff, pend_in;
   logic signed [DataW-1:0] lo_ff, lo_in;
   logic signed [DataW-1:0] hi_ff, hi_in;
   logic                    found_lo_ff, found_lo_in;
   logic                    found_hi_ff, found_hi_in;
   rsp_type                 res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    wr_en;
   slot_type                wr_slot;
   slot_type                val_rd_slot;
   logic [DataW-1:0]        time_rd;
   logic [DataW-1:0]        val_rd;
   rank_ctl_type            rank_ctl;
   logic signed [DataW-1:0] cand;
   cnt_type                 less;
   cnt_type                 leq;
   cnt_type                 k_lo;
   cnt_type                 k_hi;
   logic [DataW-1:0]        age;
   logic signed [DataW:0]   mid_sum;
   logic signed [DataW:0]   median;
   logic                    req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_en       = (state_ff == ST_WRITE);
   assign wr_slot     = slot_add(oldest_ff, held_ff);
   assign val_rd_slot = slot_add(oldest_ff, (state_ff == ST_C_RD) ? ci_ff : ja_ff);

   assign k_lo    = (held_ff - cnt_type'(1)) >> 1;
   assign k_hi    = held_ff >> 1;
   assign age     = t_ff - time_rd;
   assign mid_sum = {lo_ff[DataW-1], lo_ff} + {hi_ff[DataW-1], hi_ff};
   assign median  = mid_sum >>> 1;

   tmc_ram #(.Width(DataW), .Depth(Depth)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (t_ff),
      .rd_addr (oldest_ff),
      .rd_data (time_rd)
   );

   tmc_ram #(.Width(DataW), .Depth(Depth)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (v_ff),
      .rd_addr (val_rd_slot),
      .rd_data (val_rd)
   );

   tmc_rank u_rank (
      .clock (clock),
      .ctl   (rank_ctl),
      .data  ($signed(val_rd)),
      .cand  (cand),
      .less  (less),
      .leq   (leq)
   );

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      held_in      = held_ff;
      oldest_in    = oldest_ff;
      window_in    = window_ff;
      limit_in     = limit_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      ci_in        = ci_ff;
      ja_in        = ja_ff;
      pend_in      = pend_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      found_lo_in  = found_lo_ff;
      found_hi_in  = found_hi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rank_ctl     = '0;

      if (csr_valid & csr_ready) begin
         case (csr_index)
            CSR_WINDOW_TICKS: window_in = csr_wdata;
            CSR_CLAMP_LIMIT:  limit_in  = csr_wdata[LimitW-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               t_in = req_data.stamp;
               v_in = req_data.sample_value;
               if (!started_ff) begin
                  // first item only gets clamped
                  started_in = 1'b1;
                  res_in.filtered_value = clamp_val({req_data.sample_value[DataW-1],
                                                     req_data.sample_value}, limit_ff);
                  res_in.window_count   = '0;
                  state_in = ST_DONE;
               end else begin
                  if (held_ff == cnt_type'(Depth)) begin
                     oldest_in = slot_add(oldest_ff, cnt_type'(1));
                     held_in   = cnt_type'(Depth - 1);
                  end
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            held_in  = held_ff + cnt_type'(1);
            state_in = ST_EV_RD;
         end
         ST_EV_RD: begin
            state_in = ST_EV_CHK;
         end
         ST_EV_CHK: begin
            if ((held_ff != '0) && (age > window_ff)) begin
               oldest_in = slot_add(oldest_ff, cnt_type'(1));
               held_in   = held_ff - cnt_type'(1);
               state_in  = ST_EV_RD;
            end else if (held_ff == '0) begin
               res_in.filtered_value = '0;
               res_in.window_count   = '0;
               state_in = ST_DONE;
            end else begin
               ci_in       = '0;
               found_lo_in = 1'b0;
               found_hi_in = 1'b0;
               state_in    = ST_C_RD;
            end
         end
         ST_C_RD: begin
            state_in = ST_C_LD;
         end
         ST_C_LD: begin
            rank_ctl.load  = 1'b1;
            rank_ctl.clear = 1'b1;
            ja_in    = '0;
            pend_in  = 1'b0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            // read of entry ja goes out while the previous one is compared
            rank_ctl.cmp = pend_ff;
            if (ja_ff < held_ff) begin
               ja_in   = ja_ff + cnt_type'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if ((less <= k_lo) && (k_lo < leq)) begin
               lo_in       = cand;
               found_lo_in = 1'b1;
            end
            if ((less <= k_hi) && (k_hi < leq)) begin
               hi_in       = cand;
               found_hi_in = 1'b1;
            end
            if ((found_lo_ff || ((less <= k_lo) && (k_lo < leq))) &&
                (found_hi_ff || ((less <= k_hi) && (k_hi < leq)))) begin
               state_in = ST_MEDIAN;
            end else begin
               ci_in    = ci_ff + cnt_type'(1);
               state_in = ST_C_RD;
            end
         end
         ST_MEDIAN: begin
            res_in.filtered_value = clamp_val(median, limit_ff);
            res_in.window_count   = CountW'(held_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         held_ff      <= '0;
         oldest_ff    <= '0;
         window_ff    <= WindowReset;
         limit_ff     <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         window_ff    <= window_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      v_ff        <= v_in;
      ci_ff       <= ci_in;
      ja_ff       <= ja_in;
      pend_ff     <= pend_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      found_lo_ff <= found_lo_in;
      found_hi_ff <= found_hi_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `TMC_ASSERT_ALWAYS(a_held_bound, held_ff <= cnt_type'(Depth), "held count beyond ring depth")
   `TMC_ASSERT_ALWAYS(a_cand_in_window, (state_ff != ST_C_RD) || (ci_ff < held_ff), "candidate index past held entries")
   `TMC_ASSERT_ALWAYS(a_median_found, (state_ff != ST_MEDIAN) || (found_lo_ff && found_hi_ff), "median taken before both middle values found")
   `TMC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "item accepted while still busy")

endmodule

### rtl/tmc_ram.sv
// generic single write, single read ram with registered read data
module tmc_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tmc_rank.sv
// rank counter: one shared signed compare that counts values below and at a candidate
module tmc_rank (
   input  logic                              clock,
   input  tmc_pkg::rank_ctl_type             ctl,
   input  logic signed [tmc_pkg::DataW-1:0]  data,
   output logic signed [tmc_pkg::DataW-1:0]  cand,
   output tmc_pkg::cnt_type                  less,
   output tmc_pkg::cnt_type                  leq
);
   import tmc_pkg::*;

   logic signed [DataW-1:0] cand_ff, cand_in;
   cnt_type                 less_ff, less_in;
   cnt_type                 leq_ff, leq_in;
   logic                    is_lt;
   logic                    is_eq;

   assign is_lt = data < cand_ff;
   assign is_eq = data == cand_ff;

   always_comb begin
      cand_in = cand_ff;
      less_in = less_ff;
      leq_in  = leq_ff;
      if (ctl.load) begin
         cand_in = data;
      end
      if (ctl.clear) begin
         less_in = '0;
         leq_in  = '0;
      end else if (ctl.cmp) begin
         less_in = less_ff + cnt_type'(is_lt);
         leq_in  = leq_ff + cnt_type'(is_lt | is_eq);
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      less_ff <= less_in;
      leq_ff  <= leq_in;
   end

   assign cand = cand_ff;
   assign less = less_ff;
   assign leq  = leq_ff;

endmodule

### tb/sv/time_window_median_clamp_checker.sv
// checker for the time window median clamp block: predicts each result and compares it
module time_window_median_clamp_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  tmc_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tmc_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  tmc_pkg::csr_index_type     csr_index,
   input  logic [tmc_pkg::DataW-1:0]  csr_wdata,
   output int                         pending_medians,
   output int                         mismatch_count
);
   import tmc_pkg::*;

   logic [DataW-1:0]        win_ticks;
   logic [LimitW-1:0]       clamp_lim;
   logic [DataW-1:0]        ring_time  [Depth];
   logic signed [DataW-1:0] ring_value [Depth];
   int unsigned             head_slot;
   int unsigned             held;
   bit                      primed;
   rsp_type                 due_medians [$];

   initial begin
      pending_medians = 0;
      mismatch_count  = 0;
   end

   function automatic logic signed [DataW-1:0] clamp_to_limit(longint x);
      longint lim;
      lim = longint'({1'b0, clamp_lim});
      if (x > lim) begin
         return lim[DataW-1:0];
      end
      if (x < -lim) begin
         return DataW'(-lim);
      end
      return x[DataW-1:0];
   endfunction

   // insertion sort of the held values, oldest first
   function automatic longint held_median();
      logic signed [DataW-1:0] sorted [Depth];
      logic signed [DataW-1:0] v;
      int                      n;
      int                      i;
      int                      j;
      n = held;
      if (n == 0) begin
         return 0;
      end
      for (i = 0; i < n; i++) begin
         v = ring_value[(head_slot + i) % Depth];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      if (n % 2 == 1) begin
         return longint'(sorted[n/2]);
      end
      // floor of the mean, sum kept wide so two extremes do not overflow
      return (longint'(sorted[n/2-1]) + longint'(sorted[n/2])) >>> 1;
   endfunction

   function automatic rsp_type filter_sample(req_type s);
      rsp_type                 r;
      logic signed [DataW-1:0] sv;
      logic [DataW-1:0]        age;
      int unsigned             wr;
      sv = s.sample_value;
      if (!primed) begin
         primed           = 1'b1;
         r.filtered_value = clamp_to_limit(longint'(sv));
         r.window_count   = '0;
         return r;
      end
      if (held >= Depth) begin
         head_slot = (head_slot + 1) % Depth;
         held      = Depth - 1;
      end
      wr             = (head_slot + held) % Depth;
      ring_time[wr]  = s.stamp;
      ring_value[wr] = sv;
      held++;
      while (held > 0) begin
         age = s.stamp - ring_time[head_slot];
         if (age <= win_ticks) begin
            break;
         end
         head_slot = (head_slot + 1) % Depth;
         held--;
      end
      r.filtered_value = clamp_to_limit(held_median());
      r.window_count   = CountW'(held);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         win_ticks = WindowReset;
         clamp_lim = LimitReset;
         head_slot = 0;
         held      = 0;
         primed    = 1'b0;
         due_medians.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_TICKS: win_ticks = csr_wdata;
               CSR_CLAMP_LIMIT:  clamp_lim = csr_wdata[LimitW-1:0];
               default: ;
            endcase
         end
         // a result at this edge can only belong to an item accepted earlier
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (due_medians.size() == 0) begin
               $error("unexpected result: filtered_value %0d window_count %0d",
                      got.filtered_value, got.window_count);
               mismatch_count++;
            end else begin
               want = due_medians[0];
               due_medians.delete(0);
               if (got.filtered_value !== want.filtered_value) begin
                  $error("filtered_value: expected %0d, actual %0d",
                         want.filtered_value, got.filtered_value);
                  mismatch_count++;
               end
               if (got.window_count !== want.window_count) begin
                  $error("window_count: expected %0d, actual %0d",
                         want.window_count, got.window_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            due_medians.insert(due_medians.size(), filter_sample(req_data));
         end
      end
      pending_medians = due_medians.size();
   end

endmodule

### tb/sv/time_window_median_clamp_top_tb.sv
// testbench top for the time window median clamp block: stimulus, idling and verdict
module time_window_median_clamp_top_tb;
   import tmc_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [DataW-1:0]    csr_wdata;
   int                  pending_medians;
   int                  mismatch_count;
   bit                  steady;
   logic [DataW-1:0]    now_ticks;

   time_window_median_clamp_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   time_window_median_clamp_checker median_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_medians (pending_medians),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("tb: failure");
      $finish;
   end

   // result side stalls at random except during the steady stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = steady || ($urandom_range(99) >= 28);
      end
   end

   function automatic logic [DataW-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3, 4: return 32'($signed($urandom_range(32'h6_0000)) - 32'sh3_0000);
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken, valid low
   task automatic push_sample(input logic [DataW-1:0] t, input logic [DataW-1:0] v);
      while (!steady && $urandom_range(99) < 28) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_data.stamp        = t;
      req_data.sample_value = v;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DataW-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // lets every pending result come back before the registers change
   task automatic set_filter(input logic [DataW-1:0] win, input logic [LimitW-1:0] lim);
      req_valid = 1'b0;
      while (pending_medians != 0) begin
         @(negedge clock);
      end
      write_csr(CSR_WINDOW_TICKS, win);
      write_csr(CSR_CLAMP_LIMIT, {1'b0, lim});
      csr_valid = 1'b0;
   endtask

   task automatic random_run(input logic [DataW-1:0] win, input logic [LimitW-1:0] lim,
                             input int count, input int step_max, input bit wild_times);
      int k;
      set_filter(win, lim);
      for (k = 0; k < count; k++) begin
         if (wild_times) begin
            now_ticks = $urandom;
         end else if ($urandom_range(19) == 0) begin
            // a time that steps backwards wraps the age, which flushes the window unless it is all ones
            now_ticks = now_ticks - $urandom_range(step_max + 1);
         end else begin
            now_ticks = now_ticks + $urandom_range(step_max);
         end
         push_sample(now_ticks, pick_value());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WINDOW_TICKS;
      csr_wdata = '0;
      steady    = 1'b0;
      now_ticks = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // first item after reset is only clamped, with the reset limit
      push_sample(32'd5, 32'h8000_0000);

      set_filter(32'd10, 31'h7fff_ffff);
      push_sample(32'd0, 32'h7fff_ffff);
      push_sample(32'd0, 32'h7fff_ffff);
      push_sample(32'd1, 32'h8000_0000);
      push_sample(32'd2, 32'h8000_0000);
      push_sample(32'd3, 32'hffff_ffff);
      push_sample(32'd3, 32'h0000_0000);
      push_sample(32'd14, 32'h0001_2345);
      // age equal to the window stays, one tick more is evicted
      push_sample(32'd24, 32'hffff_fffb);
      push_sample(32'd25, 32'h0000_0007);
      push_sample(32'd20, 32'h0000_0003);
      push_sample(32'hffff_fffc, 32'h0000_0064);
      push_sample(32'h0000_0003, 32'hffff_ff9c);
      push_sample(32'h0000_0005, 32'h0000_0001);

      set_filter(32'd0, 31'd0);
      push_sample(32'd5, 32'h7fff_ffff);
      push_sample(32'd5, 32'h8000_0000);
      push_sample(32'd6, 32'h0000_0001);

      set_filter(32'hffff_ffff, 31'h0001_0000);
      push_sample(32'd6, 32'h0002_0000);
      push_sample(32'd6, 32'hfffe_0000);
      push_sample(32'd7, 32'h0000_8000);
      push_sample(32'd7, 32'hffff_0000);

      // large window keeps the ring full
      random_run(32'hffff_ffff, 31'h7fff_ffff, 250, 1000, 1'b0);
      random_run(32'd0, 31'd0, 100, 1, 1'b0);
      now_ticks = 32'hffff_ff00;
      steady    = 1'b1;
      random_run(32'd50, 31'($urandom), 300, 20, 1'b0);
      steady    = 1'b0;
      random_run($urandom, 31'h7fff_ffff, 150, 0, 1'b1);
      random_run(32'd1000000, 31'h0001_0000, 200, 70000, 1'b0);
      random_run(32'd200, 31'h7fff_0000, 200, 15, 1'b0);

      req_valid = 1'b0;
      while (pending_medians != 0) begin
         @(negedge clock);
      end
      repeat (1300) @(negedge clock);
      if (mismatch_count == 0 && pending_medians == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
